>>> src/pcsl_pkg.sv
// shared types and constants of the pulse count sensor link
`timescale 1ns / 1ps

package pcsl_pkg;

   // sequencer phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SEND   = 2'd1;
   localparam logic [1:0] PH_GUARD  = 2'd2;
   localparam logic [1:0] PH_LISTEN = 2'd3;

   // pulse qualifier phases
   localparam logic [1:0] Q_CLEAR = 2'd0;
   localparam logic [1:0] Q_LO    = 2'd1;
   localparam logic [1:0] Q_HI    = 2'd2;

   // request kinds
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // response kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_STATUS_CMD     = 3'd0;
   localparam logic [2:0] REG_CALIB_CMD      = 3'd1;
   localparam logic [2:0] REG_STATUS_RETRIES = 3'd2;
   localparam logic [2:0] REG_CALIB_RETRIES  = 3'd3;
   localparam logic [2:0] REG_STATUS_PULSES  = 3'd4;
   localparam logic [2:0] REG_CALIB_PULSES   = 3'd5;
   localparam logic [2:0] REG_STATUS_WAIT    = 3'd6;
   localparam logic [2:0] REG_CALIB_WAIT     = 3'd7;

   // frame layout
   localparam logic [7:0] FRAME_HEAD = 8'h1E;
   localparam logic [7:0] FRAME_LEN  = 8'h05;
   localparam logic [7:0] FRAME_TAIL = 8'h1F;
   localparam logic [2:0] FRAME_BEATS = 3'd5;

   // timing limits in ticks, then pulse count limits
   localparam logic [4:0] GUARD_TICKS   = 5'd15;
   localparam logic [4:0] GUARD_MAX     = 5'd31;
   localparam logic [7:0] EDGE_MAX      = 8'd255;
   localparam logic [7:0] PHASE_MIN     = 8'd3;
   localparam logic [7:0] LOW_MAX       = 8'd7;
   localparam logic [7:0] PULSE_MAX     = 8'd255;
   localparam logic [7:0] COUNT_WINDOW  = 8'd4;

   // snapshot of the block state that goes out with every response of one item
   typedef struct packed {
      logic       has_frame;
      logic [7:0] cmd;
      logic       drive_line;
      logic       busy;
      logic       done;
      logic       passed;
      logic       link_ok;
      logic [7:0] pulse_count;
   } rsp_rec_type;

   // frame byte at a given beat: head, length, command, checksum, tail
   function automatic logic [7:0] frame_byte(input logic [2:0] beat, input logic [7:0] cmd);
      logic [7:0] res;
      case (beat)
         3'd0:    res = FRAME_HEAD;
         3'd1:    res = FRAME_LEN;
         3'd2:    res = cmd;
         3'd3:    res = FRAME_HEAD + FRAME_LEN + cmd;
         3'd4:    res = FRAME_TAIL;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

>>> src/pulse_count_sensor_link_core.sv
// top level of the pulse count sensor link: command sequencer, pulse qualifier, response buffer
`timescale 1ns / 1ps

// Usage
// req channel: one item per transfer. tuser is the op (0 tick, 1 start),
// tdata carries the command byte and the sampled line level of the tick.
// rsp channel: each item gives its frame bytes first (five, on the tick that
// sends a command) and then one status response with tlast set.
// csr channel: one register write per transfer, taken at any time; csr_ready
// is always high. Write registers only while the block is idle.
// Latency: the first response of an item is valid the cycle after the item
// is accepted. A sending tick holds the response register for its frame bytes
// and status response, every other item only for its status response, so with
// rsp_tready high the block sustains one item per cycle except on sending ticks.
// The next item is accepted in the cycle its predecessor's final response transfers.
// Reset: synchronous, active high; sequencer idle, counters and status
// cleared, registers back to their default values.
// Stall: while rsp_tready is low the response holds and req_tready drops
// once the buffered item still has responses to deliver.

module pulse_count_sensor_link_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd_byte[7:0], pin_level[8], zero fill
   input  logic        req_tuser,   // op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], drive_line[8], busy_res[9],
                                    // done_res[10], passed[11], link_ok[12],
                                    // pulse_count[20:13], zero fill
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import pcsl_pkg::*;

   // configuration registers
   logic [7:0] status_cmd_ff, calib_cmd_ff;
   logic [3:0] status_retries_ff, calib_retries_ff;
   logic [7:0] status_pulses_ff, calib_pulses_ff;
   logic [9:0] status_wait_ff, calib_wait_ff;

   // link state
   logic [1:0] phase_ff, phase_in;
   logic       is_calib_ff, is_calib_in;
   logic [7:0] active_cmd_ff, active_cmd_in;
   logic [3:0] retries_ff, retries_in;
   logic [9:0] wait_ff, wait_in;
   logic [4:0] guard_ff, guard_in;
   logic [1:0] qual_ff, qual_in;
   logic [7:0] edge_timer_ff, edge_timer_in;
   logic       prev_level_ff, prev_level_in;
   logic [7:0] pulses_ff, pulses_in;
   logic       link_ff, link_in;

   // response buffer
   logic        out_valid_ff;
   logic [2:0]  beat_ff;
   rsp_rec_type rec_ff, rec_in;

   logic       req_fire, rsp_fire, last_beat;
   logic       req_op, req_pin;
   logic [7:0] req_cmd;
   logic       done, pass, send;
   logic [7:0] expect_cnt, lo_bound;
   logic [8:0] hi_bound;
   logic       on_frame_beat;

   assign req_op  = req_tuser;
   assign req_cmd = req_tdata[7:0];
   assign req_pin = req_tdata[8];

   assign last_beat = (beat_ff == (rec_ff.has_frame ? FRAME_BEATS : 3'd0));
   assign req_tready = !out_valid_ff || (rsp_tready && last_beat);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   // window bounds of the expected count
   assign expect_cnt = is_calib_ff ? calib_pulses_ff : status_pulses_ff;
   assign lo_bound   = (expect_cnt >= COUNT_WINDOW) ? expect_cnt - COUNT_WINDOW : 8'd0;
   assign hi_bound   = {1'b0, expect_cnt} + {1'b0, COUNT_WINDOW};

   // next state of one item: qualifier first, then sequencer
   always_comb begin
      phase_in      = phase_ff;
      is_calib_in   = is_calib_ff;
      active_cmd_in = active_cmd_ff;
      retries_in    = retries_ff;
      wait_in       = wait_ff;
      guard_in      = guard_ff;
      qual_in       = qual_ff;
      edge_timer_in = edge_timer_ff;
      prev_level_in = prev_level_ff;
      pulses_in     = pulses_ff;
      link_in       = link_ff;
      done          = 1'b0;
      pass          = 1'b0;
      send          = 1'b0;

      if (req_op == OP_START) begin
         // start: arm a matching command, status check wins a tie
         if (req_cmd == status_cmd_ff) begin
            is_calib_in   = 1'b0;
            retries_in    = status_retries_ff;
            active_cmd_in = req_cmd;
            phase_in      = PH_SEND;
            wait_in       = 10'd0;
         end else if (req_cmd == calib_cmd_ff) begin
            is_calib_in   = 1'b1;
            retries_in    = calib_retries_ff;
            active_cmd_in = req_cmd;
            phase_in      = PH_SEND;
            wait_in       = 10'd0;
         end
      end else begin
         // pulse qualifier, active only while listening
         if (phase_ff == PH_LISTEN) begin
            if (edge_timer_ff < EDGE_MAX) begin
               edge_timer_in = edge_timer_ff + 8'd1;
            end
            if (!req_pin && prev_level_ff) begin
               // falling edge
               if (qual_ff == Q_HI) begin
                  if (edge_timer_in < PHASE_MIN) begin
                     qual_in = Q_CLEAR;
                  end
               end else if (qual_ff != Q_LO) begin
                  edge_timer_in = 8'd0;
                  qual_in       = Q_LO;
               end
            end else if (req_pin && !prev_level_ff) begin
               // rising edge closes the low phase
               if (qual_ff == Q_LO) begin
                  if (edge_timer_in >= PHASE_MIN && edge_timer_in <= LOW_MAX) begin
                     edge_timer_in = 8'd0;
                     qual_in       = Q_HI;
                  end else begin
                     qual_in = Q_CLEAR;
                  end
               end
            end else if (req_pin && prev_level_ff) begin
               // high phase long enough counts the pulse
               if (qual_ff == Q_HI && edge_timer_in >= PHASE_MIN) begin
                  if (pulses_ff < PULSE_MAX) begin
                     pulses_in = pulses_ff + 8'd1;
                  end
                  qual_in = Q_CLEAR;
               end
            end
         end
         prev_level_in = req_pin;

         // sequencer
         case (phase_ff)
            PH_SEND: begin
               send      = 1'b1;
               qual_in   = Q_CLEAR;
               pulses_in = 8'd0;
               guard_in  = 5'd0;
               wait_in   = is_calib_ff ? calib_wait_ff : status_wait_ff;
               phase_in  = PH_GUARD;
            end
            PH_GUARD: begin
               if (wait_ff != 10'd0) begin
                  wait_in = wait_ff - 10'd1;
               end
               if (guard_ff < GUARD_MAX) begin
                  guard_in = guard_ff + 5'd1;
               end
               if (guard_in > GUARD_TICKS) begin
                  phase_in = PH_LISTEN;
               end
            end
            PH_LISTEN: begin
               if (wait_ff != 10'd0) begin
                  wait_in = wait_ff - 10'd1;
               end
               if (wait_in == 10'd0) begin
                  if (pulses_in >= lo_bound && {1'b0, pulses_in} <= hi_bound) begin
                     done = 1'b1;
                     pass = 1'b1;
                  end else if (retries_ff <= 4'd1) begin
                     retries_in = 4'd0;
                     done       = 1'b1;
                  end else begin
                     retries_in = retries_ff - 4'd1;
                     phase_in   = PH_SEND;
                  end
                  if (done) begin
                     link_in       = pass;
                     active_cmd_in = 8'd0;
                     phase_in      = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // snapshot for the responses of this item
      rec_in.has_frame   = send;
      rec_in.cmd         = active_cmd_ff;
      rec_in.drive_line  = (phase_in == PH_GUARD);
      rec_in.busy        = (phase_in != PH_IDLE);
      rec_in.done        = done;
      rec_in.passed      = pass;
      rec_in.link_ok     = link_in;
      rec_in.pulse_count = pulses_in;
   end

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         is_calib_ff   <= 1'b0;
         active_cmd_ff <= 8'd0;
         retries_ff    <= 4'd0;
         wait_ff       <= 10'd0;
         guard_ff      <= 5'd0;
         qual_ff       <= Q_CLEAR;
         edge_timer_ff <= 8'd0;
         prev_level_ff <= 1'b0;
         pulses_ff     <= 8'd0;
         link_ff       <= 1'b0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         is_calib_ff   <= is_calib_in;
         active_cmd_ff <= active_cmd_in;
         retries_ff    <= retries_in;
         wait_ff       <= wait_in;
         guard_ff      <= guard_in;
         qual_ff       <= qual_in;
         edge_timer_ff <= edge_timer_in;
         prev_level_ff <= prev_level_in;
         pulses_ff     <= pulses_in;
         link_ff       <= link_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         status_cmd_ff     <= 8'd1;
         calib_cmd_ff      <= 8'd2;
         status_retries_ff <= 4'd3;
         calib_retries_ff  <= 4'd3;
         status_pulses_ff  <= 8'd20;
         calib_pulses_ff   <= 8'd40;
         status_wait_ff    <= 10'd250;
         calib_wait_ff     <= 10'd400;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_STATUS_CMD:     status_cmd_ff     <= csr_data[7:0];
            REG_CALIB_CMD:      calib_cmd_ff      <= csr_data[7:0];
            REG_STATUS_RETRIES: status_retries_ff <= csr_data[3:0];
            REG_CALIB_RETRIES:  calib_retries_ff  <= csr_data[3:0];
            REG_STATUS_PULSES:  status_pulses_ff  <= csr_data[7:0];
            REG_CALIB_PULSES:   calib_pulses_ff   <= csr_data[7:0];
            REG_STATUS_WAIT:    status_wait_ff    <= csr_data;
            REG_CALIB_WAIT:     calib_wait_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // response buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= 3'd0;
      end else if (req_fire) begin
         out_valid_ff <= 1'b1;
         beat_ff      <= 3'd0;
      end else if (rsp_fire) begin
         if (last_beat) begin
            out_valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 3'd1;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rec_ff <= rec_in;
      end
   end

   // response fields: frame beats then the status response
   assign on_frame_beat = rec_ff.has_frame && (beat_ff != FRAME_BEATS);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_beat;
   assign rsp_tuser  = on_frame_beat ? KIND_FRAME : KIND_STATUS;
   assign rsp_tdata  = {3'b000,
                        rec_ff.pulse_count,
                        rec_ff.link_ok,
                        on_frame_beat ? 1'b0 : rec_ff.passed,
                        on_frame_beat ? 1'b0 : rec_ff.done,
                        rec_ff.busy,
                        rec_ff.drive_line,
                        on_frame_beat ? frame_byte(beat_ff, rec_ff.cmd) : 8'h00};

   // checks
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_STATUS)
      else $error("final response of an item is not a status response");

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> beat_ff <= FRAME_BEATS)
      else $error("response beat counter out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> !rsp_tdata[9])
      else $error("finished command still reported busy");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[9])
      else $error("line driven while no command runs");

   a_pass_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[10])
      else $error("pass flag without a finished command");

   a_frame_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !last_beat |=> out_valid_ff)
      else $error("item dropped before its final response");

endmodule
